// File: rtl/sorted_list_priority_queue_core_assert.svh
// Assertion macros for the sorted-list priority queue RTL.
`ifndef SORTED_LIST_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_LIST_PRIORITY_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTH
// Check a property at every rising clock edge outside reset.
`define SLPQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// Check a property at every rising clock edge, reset included.
`define SLPQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define SLPQ_ASSERT(label, clk, rst_n, prop)
`define SLPQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: rtl/slpq_pkg.sv
// Package with types, codes and defaults of the sorted-list priority queue.
package slpq_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int KEY_FIELD_W   = 32;
    localparam int COUNT_FIELD_W = 5;
    localparam int STATUS_W      = 2;
    localparam int OUT_TDATA_W   = KEY_FIELD_W + 1 + COUNT_FIELD_W + STATUS_W;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic ins_en;
        logic rem_en;
        logic min_first;
    } t_slpq_ctrl;

endpackage

// File: rtl/slpq_cell.sv
// One entry of the sorted list: holds a key and a valid bit, shifts with its neighbors.
module slpq_cell #(
    parameter int KEY_WIDTH = slpq_pkg::KEY_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  slpq_pkg::t_slpq_ctrl  i_ctrl,
    input  logic [KEY_WIDTH-1:0]  i_new_key,
    input  logic                  i_prev_take,
    input  logic [KEY_WIDTH-1:0]  i_prev_key,
    input  logic                  i_prev_valid,
    input  logic [KEY_WIDTH-1:0]  i_next_key,
    input  logic                  i_next_valid,
    output logic [KEY_WIDTH-1:0]  o_key,
    output logic                  o_valid,
    output logic                  o_take
);

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;
    logic                 r_valid;
    logic                 n_valid;
    logic                 w_hit;
    logic                 w_take;

    // The new key goes here when it strictly precedes the stored key,
    // or into the first empty cell.
    assign w_hit  = r_valid && (i_ctrl.min_first ? (i_new_key < r_key)
                                                 : (i_new_key > r_key));
    assign w_take = w_hit || !r_valid;

    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_ctrl.ins_en) begin
            if (i_prev_take) begin
                n_key   = i_prev_key;
                n_valid = i_prev_valid;
            end else if (w_take) begin
                n_key   = i_new_key;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.rem_en) begin
            n_key   = i_next_key;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;
    assign o_take  = i_prev_take || w_take;

endmodule

// File: rtl/sorted_list_priority_queue_core.sv
// Top level of the sorted-list priority queue: a chain of key cells with stream ports.
//
//  channel   direction  signals                         content
//  s_axis    in         tvalid tready tdata tuser       request: key, request type
//  m_axis    out        tvalid tready tdata             result: top key, flags, count
//  cfg       in         valid ready data                order_min_first register
//
// For each request every cell compares the new key with its own in
// parallel and the insert position ripples down the chain as a prefix OR, so one
// request can be accepted per cycle while the result register is free or drained.
// Reset (synchronous, active low) clears the cell valid bits, the count and the
// result register; stored keys need no clearing. A stalled result holds the
// request port off until it is taken.
module sorted_list_priority_queue_core #(
    parameter int CAPACITY  = slpq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = slpq_pkg::KEY_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side request
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [slpq_pkg::KEY_FIELD_W-1:0]  i_s_axis_tdata,  // [31:0] key
    input  logic                              i_s_axis_tuser,  // [0] req_type
    // master side result
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [31:0] top_key, [32] not_empty, [37:33] entry_count, [39:38] status
    output logic [slpq_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // configuration write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_data       // [0] order_min_first
);

`include "sorted_list_priority_queue_core_assert.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [KEY_WIDTH-1:0]  w_key  [CAPACITY];
    logic [CAPACITY-1:0]   w_valid;
    logic [CAPACITY-1:0]   w_take;
    logic [KEY_WIDTH-1:0]  w_new_key;

    logic                  r_min_first;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W-1:0]      w_count_dec;
    slpq_pkg::t_status     r_status;
    slpq_pkg::t_status     n_status;
    logic                  r_out_valid;

    logic                  w_accept;
    logic                  w_is_remove;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_ins_drop;
    logic [CAPACITY-1:0]   w_valid_inc;
    slpq_pkg::t_slpq_ctrl  w_ctrl;
    logic [slpq_pkg::KEY_FIELD_W-1:0] w_top_key;

    // Take a new request whenever the result register is empty or drains now.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_remove     = (slpq_pkg::t_req'(i_s_axis_tuser) == slpq_pkg::REQ_REMOVE);
    assign w_new_key       = KEY_WIDTH'(i_s_axis_tdata);

    // Valid bits fill from the head, so the last and first cells tell full and empty.
    assign w_full  = w_valid[CAPACITY-1];
    assign w_empty = !w_valid[0];

    assign w_ctrl.ins_en    = w_accept && !w_is_remove && !w_full;
    assign w_ctrl.rem_en    = w_accept && w_is_remove && !w_empty;
    assign w_ctrl.min_first = r_min_first;

    assign w_ins_drop  = w_accept && !w_is_remove && w_full;
    assign w_count_dec = r_count - 1'b1;
    assign w_valid_inc = w_valid + 1'b1;

    // Build the chain: each cell sees its upstream key and take chain for
    // inserts and its downstream key for removes.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                 w_prev_take;
        logic [KEY_WIDTH-1:0] w_prev_key;
        logic                 w_prev_valid;
        logic [KEY_WIDTH-1:0] w_next_key;
        logic                 w_next_valid;

        if (g == 0) begin : g_head
            assign w_prev_take  = 1'b0;
            assign w_prev_key   = '0;
            assign w_prev_valid = 1'b0;
        end else begin : g_body
            assign w_prev_take  = w_take[g-1];
            assign w_prev_key   = w_key[g-1];
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_key   = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_key   = w_key[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        slpq_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_new_key    (w_new_key),
            .i_prev_take  (w_prev_take),
            .i_prev_key   (w_prev_key),
            .i_prev_valid (w_prev_valid),
            .i_next_key   (w_next_key),
            .i_next_valid (w_next_valid),
            .o_key        (w_key[g]),
            .o_valid      (w_valid[g]),
            .o_take       (w_take[g])
        );
    end

    // Track the count and status of the request being accepted.
    always_comb begin
        n_count  = r_count;
        n_status = r_status;
        if (w_accept) begin
            if (w_is_remove) begin
                if (w_empty) begin
                    n_status = slpq_pkg::ST_EMPTY;
                end else begin
                    n_status = slpq_pkg::ST_OK;
                    n_count  = w_count_dec;
                end
            end else begin
                if (w_full) begin
                    n_status = slpq_pkg::ST_FULL;
                end else begin
                    n_status = slpq_pkg::ST_OK;
                    n_count  = r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_status    <= slpq_pkg::ST_OK;
            r_out_valid <= 1'b0;
            r_min_first <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_status <= n_status;
            // Raise on an accepted request, drop once the result is taken.
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_min_first <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    // The cells hold still while a result waits, so read the head directly.
    assign w_top_key       = w_valid[0] ? slpq_pkg::KEY_FIELD_W'(w_key[0]) : '0;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_status,
                              slpq_pkg::COUNT_FIELD_W'(r_count),
                              w_valid[0],
                              w_top_key};

    // The count always matches the number of occupied cells.
    `SLPQ_ASSERT(a_count_matches, i_clk, i_rst_n, r_count == CNT_W'($countones(w_valid)))
    // Occupied cells form one run starting at the head.
    `SLPQ_ASSERT(a_valid_prefix, i_clk, i_rst_n, (w_valid_inc & w_valid) == '0)
    // An insert into a full queue is flagged and leaves the count alone.
    `SLPQ_ASSERT(a_full_flag, i_clk, i_rst_n, w_ins_drop |=> r_status == slpq_pkg::ST_FULL)
    `SLPQ_ASSERT(a_full_hold, i_clk, i_rst_n, w_ins_drop |=> $stable(r_count))
    // A remove from a non-empty queue takes exactly one entry.
    `SLPQ_ASSERT(a_remove_dec, i_clk, i_rst_n, w_ctrl.rem_en |=> r_count == $past(w_count_dec))

endmodule

// File: bench/tb_sorted_list_priority_queue_core.sv
// Self-checking testbench for the sorted-list priority queue core.
module tb_sorted_list_priority_queue_core;
    timeunit 1ns;
    timeprecision 1ps;

    import slpq_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;

    // One request as offered on the slave side.
    typedef struct {
        t_req        req;
        logic [31:0] key;
    } t_request;

    // Result layout, highest field first so it overlays o_m_axis_tdata.
    typedef struct packed {
        t_status                  status;
        logic [COUNT_FIELD_W-1:0] entry_count;
        logic                     not_empty;
        logic [KEY_FIELD_W-1:0]   top_key;
    } t_queue_view;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [KEY_FIELD_W-1:0] i_s_axis_tdata = '0;   // [31:0] key
    logic                   i_s_axis_tuser = 1'b0; // [0] req_type
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [31:0] top_key, [32] not_empty, [37:33] entry_count, [39:38] status
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_data = 1'b0;     // [0] order_min_first

    sorted_list_priority_queue_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the queue contents and the order setting.
    logic [31:0] shadow_keys [CAPACITY];
    int          shadow_count = 0;
    logic        shadow_min_first = 1'b0;

    t_request    request_backlog [$];
    t_queue_view expected_views [$];

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    int  rx_hold_cycles = 0;
    int  queued_requests = 0;
    int  accepted_requests = 0;
    int  error_count = 0;
    int  full_drops = 0;
    int  empty_removes = 0;
    int  insert_count = 0;
    int  remove_count = 0;
    bit  request_fired = 1'b0;

    // Apply one request to the shadow queue and return the view it leaves.
    function automatic t_queue_view apply_request(t_req req, logic [31:0] key);
        t_queue_view view;
        int          pos;
        bit          ahead;
        view.status = ST_OK;
        if (req == REQ_INSERT) begin
            insert_count++;
            if (shadow_count >= CAPACITY) begin
                view.status = ST_FULL;
                full_drops++;
            end else begin
                pos = shadow_count;
                for (int i = 0; i < shadow_count; i++) begin
                    ahead = shadow_min_first ? (key < shadow_keys[i]) : (key > shadow_keys[i]);
                    if (ahead) begin
                        pos = i;
                        break;
                    end
                end
                for (int i = shadow_count; i > pos; i--)
                    shadow_keys[i] = shadow_keys[i-1];
                shadow_keys[pos] = key;
                shadow_count++;
            end
        end else begin
            remove_count++;
            if (shadow_count == 0) begin
                view.status = ST_EMPTY;
                empty_removes++;
            end else begin
                for (int i = 1; i < shadow_count; i++)
                    shadow_keys[i-1] = shadow_keys[i];
                shadow_count--;
            end
        end
        view.top_key     = (shadow_count > 0) ? shadow_keys[0] : '0;
        view.not_empty   = (shadow_count > 0);
        view.entry_count = shadow_count[COUNT_FIELD_W-1:0];
        return view;
    endfunction

    // Record accepted requests and predict their results.
    always @(posedge i_clk) begin
        request_fired <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            expected_views.push_back(apply_request(t_req'(i_s_axis_tuser), i_s_axis_tdata));
            accepted_requests++;
        end
    end

    // Request driver: hold a request until taken, then offer the next or idle.
    always @(negedge i_clk) begin
        t_request next_req;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || request_fired) begin
            if (request_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_req = request_backlog.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= next_req.key;
                i_s_axis_tuser  <= next_req.req;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result ready: a long hold-off when asked, otherwise random stalls.
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles  <= rx_hold_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Result monitor: compare every taken result with the oldest prediction.
    always @(posedge i_clk) begin
        t_queue_view got;
        t_queue_view want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_queue_view'(o_m_axis_tdata);
            if (expected_views.size() == 0) begin
                $error("unexpected result %h", o_m_axis_tdata);
                error_count++;
            end else begin
                want = expected_views.pop_front();
                if (got.top_key !== want.top_key) begin
                    $error("top_key expected %h got %h", want.top_key, got.top_key);
                    error_count++;
                end
                if (got.not_empty !== want.not_empty) begin
                    $error("not_empty expected %0d got %0d", want.not_empty, got.not_empty);
                    error_count++;
                end
                if (got.entry_count !== want.entry_count) begin
                    $error("entry_count expected %0d got %0d",
                           want.entry_count, got.entry_count);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, got.status);
                    error_count++;
                end
            end
        end
    end

    task automatic add_request(t_req req, logic [31:0] key);
        t_request r;
        r.req = req;
        r.key = key;
        request_backlog.push_back(r);
        queued_requests++;
    endtask

    // Wait until every queued request is taken and every result has come back.
    task automatic wait_drained();
        while (accepted_requests != queued_requests || expected_views.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_order(logic min_first);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= min_first;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_min_first = min_first;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(3))
            0:       return $urandom_range(7);                 // many ties
            1:       return 32'hFFFF_FFF8 | $urandom_range(7); // near the top
            default: return $urandom();
        endcase
    endfunction

    // Queue random requests in bursts whose insert share sweeps the fill level.
    task automatic add_random(int n);
        int burst;
        int ins_pct;
        burst = 0;
        ins_pct = 50;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(8, 40);
                case ($urandom_range(3))
                    0:       ins_pct = 15;
                    1:       ins_pct = 50;
                    2:       ins_pct = 85;
                    default: ins_pct = 97;
                endcase
            end
            burst--;
            if ($urandom_range(99) < ins_pct)
                add_request(REQ_INSERT, pick_key());
            else
                add_request(REQ_REMOVE, $urandom());
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Largest first, sender 35% idle, receiver 57% idle.
        tx_idle_pct = 35;
        rx_idle_pct = 57;
        write_order(1'b0);

        // Directed: remove from empty with a key that must be ignored,
        // extremes and ties, fill past capacity, then drain a few.
        add_request(REQ_REMOVE, 32'hFFFF_FFFF);
        add_request(REQ_INSERT, 32'h0000_0000);
        add_request(REQ_INSERT, 32'hFFFF_FFFF);
        add_request(REQ_INSERT, 32'h8000_0000);
        add_request(REQ_INSERT, 32'h8000_0000);
        add_request(REQ_INSERT, 32'h0000_0001);
        for (int i = 0; i < 11; i++)
            add_request(REQ_INSERT, 32'h5555_5555 ^ (32'h1 << (i * 3)));
        add_request(REQ_INSERT, 32'h7FFF_FFFF); // dropped: queue full
        add_request(REQ_REMOVE, 32'h0);
        add_request(REQ_REMOVE, 32'hAAAA_AAAA);
        add_request(REQ_REMOVE, 32'h0);
        wait_drained();

        add_random(500);
        wait_drained();

        // Flip to smallest first with entries still stored; nothing is resorted.
        tx_idle_pct = 57;
        rx_idle_pct = 35;
        write_order(1'b1);
        add_request(REQ_INSERT, 32'h0000_0000);
        add_request(REQ_INSERT, 32'hFFFF_FFFF);
        add_request(REQ_REMOVE, 32'h0);
        add_random(500);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering requests.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        @(posedge i_clk);
        rx_hold_cycles = 300;
        add_random(80);
        wait_drained();

        write_order(1'b0);
        add_random(350);
        wait_drained();
        write_order(1'b1);
        add_random(50);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (expected_views.size() != 0) begin
            $error("%0d results never arrived", expected_views.size());
            error_count++;
        end

        $display("Covered %0d requests: %0d inserts (%0d dropped full), %0d removes (%0d empty)",
                 accepted_requests, insert_count, full_drops, remove_count, empty_removes);
        $display("Both orders used, order flipped with entries held, %0d mismatches",
                 error_count);
        if (error_count == 0) begin
            $display("sorted_list_priority_queue_core verification clean");
        end else begin
            $display("sorted_list_priority_queue_core verification failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #4ms;
        $display("sorted_list_priority_queue_core verification failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/slpq_pkg.sv
rtl/slpq_cell.sv
rtl/sorted_list_priority_queue_core.sv
bench/tb_sorted_list_priority_queue_core.sv
